[sv/u8u16_pkg.sv]
// Shared types, constants and byte-class functions for the UTF-8 to UTF-16 length counter.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int FIELD_BITS     = 24;

    localparam logic [FIELD_BITS-1:0] OUT_MAX       = 24'hFFFFFF;
    localparam logic [FIELD_BITS-1:0] MAX_UNITS_RST = 24'd10000;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] utf16_units;
        logic                  over_limit;
        logic                  count_saturated;
    } out_item_t;

    // Outcome of scanning one window of bytes.
    typedef struct packed {
        logic [2:0][7:0] pend_bytes;
        logic [1:0]      pend_count;
        logic [2:0]      units;
    } scan_t;

    // Length of the sequence that a lead byte opens (1 for anything else).
    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] n;
        n = 3'd1;
        if ((lead & LEAD2_MASK) == LEAD2_CODE)
            n = 3'd2;
        else if ((lead & LEAD3_MASK) == LEAD3_CODE)
            n = 3'd3;
        else if ((lead & LEAD4_MASK) == LEAD4_CODE)
            n = 3'd4;
        return n;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_CODE;
    endfunction

endpackage

[sv/u8u16_scan.sv]
// Window scan: resolve up to four buffered bytes into UTF-16 units and leftover bytes.
`timescale 1ns / 1ps

module u8u16_scan
    import u8u16_pkg::*;
(
    input  logic [2:0][7:0] pend_bytes,
    input  logic [1:0]      pend_count,
    input  in_item_t        item,
    output scan_t           scan
);

    logic [3:0][7:0] win;
    logic [2:0]      cnt;
    logic [2:0]      units;
    logic            stop;
    logic [2:0]      n;
    logic [2:0]      take;
    logic [2:0]      u;
    logic            ok;

    always_comb
    begin
        win   = {8'h00, pend_bytes};
        cnt   = {1'b0, pend_count};
        units = 3'd0;
        stop  = 1'b0;
        n     = 3'd1;
        take  = 3'd1;
        u     = 3'd1;
        ok    = 1'b0;
        if (item.byte_present)
        begin
            win[pend_count] = item.data_byte;
            cnt             = cnt + 3'd1;
        end

        // A pass that does not stop takes at least one byte; four passes suffice.
        for (int it = 0; it < 4; it++)
        begin
            if (!stop && cnt != 3'd0)
            begin
                n    = seq_len(win[0]);
                take = 3'd1;
                u    = 3'd1;
                if (cnt >= n)
                begin
                    ok = (n < 3'd2 || is_cont(win[1])) &&
                         (n < 3'd3 || is_cont(win[2])) &&
                         (n < 3'd4 || is_cont(win[3]));
                    if (ok)
                    begin
                        take = n;
                        if (n == 3'd4 && (win[0][2:0] != 3'd0 || win[1][5:4] != 2'd0))
                            u = 3'd2;
                    end
                end
                else if (!item.end_of_string)
                begin
                    stop = 1'b1;
                end
                if (!stop)
                begin
                    units = units + u;
                    win   = win >> {take, 3'b000};
                    cnt   = cnt - take;
                end
            end
        end

        scan.pend_bytes = win[2:0];
        scan.pend_count = cnt[1:0];
        scan.units      = units;
    end

endmodule

[sv/utf8_to_utf16_length_counter.sv]
// Top level: UTF-8 byte stream in, UTF-16 code unit count per string out.
`timescale 1ns / 1ps
// An accepted end-of-string item passes through the input register and then the result register to its result item.
// Throughput: 1 item per cycle when not stalled; the input register feeds a combinational window scan.
// An end item stalls only while the result register is full and stalled.
// Reset: clears pending bytes, running count, saturation flag and both valid
// flags; max_units returns to 10000.

module utf8_to_utf16_length_counter
    import u8u16_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_wr_en,
    input  logic [FIELD_BITS-1:0] cfg_wr_data
);

    // Compare width wide enough for both the counter and the 24-bit fields.
    localparam int CMP_W = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
    localparam logic [CMP_W-1:0] CNT_MAX_EXT = CMP_W'({COUNT_BITS{1'b1}});
    localparam logic [CMP_W-1:0] OUT_MAX_EXT = CMP_W'(OUT_MAX);

    // Input register
    logic     in_valid_reg;
    in_item_t in_item_reg;

    // String state
    logic [2:0][7:0]       pend_bytes_reg, pend_bytes_next;
    logic [1:0]            pend_count_reg, pend_count_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  ovf_reg, ovf_next;
    logic [FIELD_BITS-1:0] max_units_reg;

    // Result register
    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    scan_t                 scan;
    logic                  advance;
    logic [COUNT_BITS:0]   sum;
    logic [CMP_W-1:0]      total_ext;
    logic [CMP_W-1:0]      max_ext;

    // Hold an end item while the result slot is occupied and stalled; every
    // other item goes through the scan in the cycle after it is accepted.
    assign advance  = in_valid_reg &&
                      (!in_item_reg.end_of_string || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    u8u16_scan u_scan
    (
        .pend_bytes (pend_bytes_reg),
        .pend_count (pend_count_reg),
        .item       (in_item_reg),
        .scan       (scan)
    );

    // Saturating add; at most four units per item, so one carry bit suffices.
    always_comb
    begin
        sum        = {1'b0, total_reg} + (COUNT_BITS + 1)'(scan.units);
        total_next = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
        ovf_next   = ovf_reg | sum[COUNT_BITS];

        total_ext = CMP_W'(total_next);
        max_ext   = CMP_W'(max_units_reg);

        out_item_next.utf16_units     = (total_ext > OUT_MAX_EXT) ? OUT_MAX
                                                                  : total_ext[FIELD_BITS-1:0];
        out_item_next.over_limit      = (total_ext > max_ext) ||
                                        (ovf_next && (max_ext <= CNT_MAX_EXT));
        out_item_next.count_saturated = ovf_next;

        // Drop all string state after an end item.
        if (in_item_reg.end_of_string)
        begin
            pend_bytes_next = '0;
            pend_count_next = 2'd0;
        end
        else
        begin
            pend_bytes_next = scan.pend_bytes;
            pend_count_next = scan.pend_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            pend_bytes_reg <= '0;
            pend_count_reg <= 2'd0;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            max_units_reg  <= MAX_UNITS_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;

            if (cfg_wr_en)
                max_units_reg <= cfg_wr_data;

            if (advance)
            begin
                pend_bytes_reg <= pend_bytes_next;
                pend_count_reg <= pend_count_next;
                if (in_item_reg.end_of_string)
                begin
                    total_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    total_reg <= total_next;
                    ovf_reg   <= ovf_next;
                end
            end

            // Load a result on an end item; otherwise clear once it is taken.
            if (advance && in_item_reg.end_of_string)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
        if (advance && in_item_reg.end_of_string)
            out_item_reg <= out_item_next;
    end

endmodule
